[sv/mcdds_pkg.sv]
// shared types, codes and the sine table of the multichannel dds mixer
`default_nettype none

package mcdds_pkg;

    // input modes
    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // waveform codes, anything else is silent
    localparam logic [2:0] WF_SINE     = 3'd0;
    localparam logic [2:0] WF_SQUARE   = 3'd1;
    localparam logic [2:0] WF_SAW      = 3'd2;
    localparam logic [2:0] WF_TRIANGLE = 3'd3;

    localparam int RAW_W  = 10;
    localparam int PROD_W = 19;

    typedef struct packed {
        logic [15:0] phase;
        logic [15:0] step;
        logic [2:0]  wave;
        logic [7:0]  gain;
    } dds_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_TICK,
        ST_DRAIN,
        ST_NORM,
        ST_DIV,
        ST_DONE
    } dds_state_t;

    localparam logic [7:0] SINE_ROM [0:255] = '{
        8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
        8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
        8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
        8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
        8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
        8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
        8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
        8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
        8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
        8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
        8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
        8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
        8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
        8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
        8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
        8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
        8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
        8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
        8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
        8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
        8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
        8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
    };

    // doubled raw waveform value from the phase msbs
    function automatic logic signed [RAW_W-1:0] raw_doubled(
        input logic [2:0] code,
        input logic [7:0] hi
    );
        logic [7:0] t;
        logic signed [RAW_W-1:0] r;
        t = hi[7] ? (8'd255 - hi) : hi;
        case (code)
            WF_SINE:     r = $signed({1'b0, SINE_ROM[hi], 1'b0}) - 10'sd255;
            WF_SQUARE:   r = hi[7] ? 10'sd254 : -10'sd256;
            WF_SAW:      r = $signed({1'b0, hi, 1'b0}) - 10'sd256;
            WF_TRIANGLE: r = $signed({1'b0, t[6:0], 2'b00}) - 10'sd256;
            default:     r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/mcdds_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module mcdds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/multichannel_dds_wave_mixer.sv]
// top level of the multichannel dds wave mixer
`default_nettype none

// Multichannel DDS wave mixer. Each channel keeps a 16-bit phase accumulator,
// a 16-bit phase step, a waveform code (sine, square, saw, triangle; other
// codes are silent) and an unsigned Q1.7 volume; a nonzero volume makes the
// channel active. A set word (mode 0) loads one channel's step, waveform and
// volume, keeps its phase, and produces no output; channel numbers at or
// above CHANNELS are dropped. A tick word (mode 1) mixes all active channels,
// advances their phases and produces one unsigned 8-bit sample, midpoint 127.
// All channel state sits in one RAM of CHANNELS entries that is walked once
// per tick, one channel per cycle, read and, for active channels, written back
// with the new phase. From its acceptance until the next word can be taken a
// tick goes through the channel walk, the drain of the read, waveform,
// multiply and accumulate stages, the offset and range check, the
// multiplication by the reciprocal of CHANNELS (skipped when the check clamps)
// and the load of the output register.
// A set word reads the entry, then writes it back. The result
// sits in an output register, so the next word is taken while it waits; a
// second sample finished before the first has left holds the block.
// After reset all channels are silent with zero phase; no clearing pass.

module multichannel_dds_wave_mixer
    import mcdds_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input words
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [2:0]  channel,
    input  wire logic [15:0] phase_step,
    input  wire logic [2:0]  wave,
    input  wire logic [7:0]  volume,
    // output words
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       sample
);

    // address width of the channel ram
    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W   = $clog2(CHANNELS);
    // accumulator holds CHANNELS products of up to 18 bits plus the offset
    localparam int ACC_W  = 20 + CH_W;
    // numerator after the divide by 256
    localparam int REM_W  = ACC_W - 9;
    localparam int ENT_W  = $bits(dds_entry_t);
    localparam logic signed [ACC_W-1:0] OFFSET = ACC_W'(32640 * CHANNELS);
    localparam logic [REM_W-1:0] LIMIT = REM_W'(256 * CHANNELS);
    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);
    // rounded-up reciprocal of CHANNELS, exact for every numerator below LIMIT
    localparam int RECIP_SH = 24;
    localparam longint RECIP_FULL =
        ((longint'(1) << RECIP_SH) + longint'(CHANNELS) - longint'(1)) / longint'(CHANNELS);
    localparam logic [RECIP_SH:0] RECIP = (RECIP_SH+1)'(RECIP_FULL);
    localparam int QP_W = REM_W + RECIP_SH + 1;

    dds_state_t state_reg, state_next;

    // channel walk
    logic [AW-1:0] idx_reg, idx_next;

    // latched set word
    logic [AW-1:0] set_ch_reg,   set_ch_next;
    logic [15:0]   set_step_reg, set_step_next;
    logic [2:0]    set_wave_reg, set_wave_next;
    logic [7:0]    set_vol_reg,  set_vol_next;

    // per-entry written flags, an unwritten entry reads as all zero
    logic [CHANNELS-1:0] valid_reg, valid_next;
    logic                vld_q_reg, vld_q_next;

    // tick pipeline: ram read, waveform, multiply, accumulate
    logic                      rd_pend_reg, rd_pend_next;
    logic [AW-1:0]             rd_addr_q_reg, rd_addr_q_next;
    logic                      s1_vld_reg, s1_vld_next;
    logic signed [RAW_W-1:0]   raw_reg, raw_next;
    logic [7:0]                gain_reg, gain_next;
    logic                      s2_vld_reg, s2_vld_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    // final divide by CHANNELS
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [7:0]       quo_reg, quo_next;

    // output register
    logic       out_vld_reg, out_vld_next;
    logic [7:0] sample_reg, sample_next;

    // ram ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    dds_entry_t        ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    dds_entry_t              entry;
    logic signed [ACC_W-1:0] num;
    logic [QP_W-1:0]         quo_prod;
    logic                    in_acc;

    mcdds_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_vld_reg;
    assign sample    = sample_reg;

    // an entry never written holds the reset state
    assign entry    = vld_q_reg ? dds_entry_t'(ram_rdata) : '0;
    assign num      = acc_reg + OFFSET;
    // quotient sits in the bits above the reciprocal's fraction
    assign quo_prod = QP_W'(rem_reg) * QP_W'(RECIP);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        set_ch_next    = set_ch_reg;
        set_step_next  = set_step_reg;
        set_wave_next  = set_wave_reg;
        set_vol_next   = set_vol_reg;
        valid_next     = valid_reg;
        vld_q_next     = vld_q_reg;
        rd_pend_next   = 1'b0;
        rd_addr_q_next = rd_addr_q_reg;
        s1_vld_next    = 1'b0;
        raw_next       = raw_reg;
        gain_next      = gain_reg;
        s2_vld_next    = s1_vld_reg;
        prod_next      = raw_reg * $signed({1'b0, gain_reg});
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_vld_next   = out_vld_reg && !out_ready;
        sample_next    = sample_reg;
        ram_we         = 1'b0;
        ram_waddr      = rd_addr_q_reg;
        ram_wdata      = entry;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;

        // accumulate stage
        if (s2_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        // waveform stage and phase write-back for active channels
        if (rd_pend_reg && (entry.gain != 8'd0))
        begin
            ram_we      = 1'b1;
            ram_waddr   = rd_addr_q_reg;
            ram_wdata   = entry;
            ram_wdata.phase = entry.phase + entry.step;
            s1_vld_next = 1'b1;
            raw_next    = raw_doubled(entry.wave, entry.phase[15:8]);
            gain_next   = entry.gain;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    set_ch_next   = AW'(channel);
                    set_step_next = phase_step;
                    set_wave_next = wave;
                    set_vol_next  = volume;
                    if (mode == MODE_TICK)
                    begin
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = ST_TICK;
                    end
                    else if (32'(channel) < CHANNELS)
                    begin
                        state_next = ST_SET_RD;
                    end
                end
            end
            ST_SET_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = set_ch_reg;
                vld_q_next = valid_reg[set_ch_reg];
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                // keep the phase, replace the tone
                ram_we          = 1'b1;
                ram_waddr       = set_ch_reg;
                ram_wdata.phase = entry.phase;
                ram_wdata.step  = set_step_reg;
                ram_wdata.wave  = set_wave_reg;
                ram_wdata.gain  = set_vol_reg;
                state_next      = ST_IDLE;
            end
            ST_TICK:
            begin
                ram_re         = 1'b1;
                ram_raddr      = idx_reg;
                vld_q_next     = valid_reg[idx_reg];
                rd_pend_next   = 1'b1;
                rd_addr_q_next = idx_reg;
                if (idx_reg == LAST_CH)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_pend_reg && !s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (num[ACC_W-1])
                begin
                    quo_next   = 8'd0;
                    state_next = ST_DONE;
                end
                else if (num[ACC_W-2:8] >= LIMIT)
                begin
                    quo_next   = 8'd255;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = num[ACC_W-2:8];
                    quo_next   = 8'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // divide by CHANNELS through the reciprocal
                quo_next   = quo_prod[RECIP_SH+7:RECIP_SH];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_vld_next = 1'b1;
                    sample_next  = quo_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            valid_reg   <= '0;
            vld_q_reg   <= 1'b0;
            rd_pend_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
            vld_q_reg   <= vld_q_next;
            rd_pend_reg <= rd_pend_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_ch_reg    <= set_ch_next;
        set_step_reg  <= set_step_next;
        set_wave_reg  <= set_wave_next;
        set_vol_reg   <= set_vol_next;
        rd_addr_q_reg <= rd_addr_q_next;
        raw_reg       <= raw_next;
        gain_reg      <= gain_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        sample_reg    <= sample_next;
    end

    // mixing pipeline only runs during the channel walk and its drain
    a_pipe_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_pend_reg || s1_vld_reg || s2_vld_reg) |->
        (state_reg == ST_TICK || state_reg == ST_DRAIN))
        else $error("mix pipeline busy outside a tick");

    // written flags are never lost
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("entry written flag cleared");

    // numerator given to the reciprocal multiply is below the clamp limit
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < LIMIT))
        else $error("divider numerator out of range");

    // a result only loads from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("sample loaded outside the done state");

endmodule

`default_nettype wire
